>>> rtl/drdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drdf_pkg
// Shared types and constants of the detection row decode filter.
// ----------------------------------------------------------------------------
package drdf_pkg;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int COORD_W  = 40;
    localparam int LABEL_W  = 7;
    localparam int POS_W    = 8;
    localparam int THRESH_W = 17;
    localparam int OFFSET_W = 16;
    localparam int NCLASS_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int OFF_PROD_W = LABEL_W + OFFSET_W;
    localparam int FRAC_W     = 16;

    // Class count limits: the label field bounds the usable count
    localparam int MAX_CLASSES = 128;
    localparam int LABEL_LIMIT = 1 << LABEL_W;
    localparam int CLASS_CAP   = (MAX_CLASSES < LABEL_LIMIT) ? MAX_CLASSES : LABEL_LIMIT;
    localparam logic [NCLASS_W-1:0] CLASS_CAP_W = NCLASS_W'(CLASS_CAP);

    // Row layout
    localparam logic [POS_W-1:0] POS_BOX_END     = 8'd4;
    localparam logic [POS_W-1:0] POS_OBJ         = 8'd4;
    localparam logic [POS_W-1:0] POS_FIRST_CLASS = 8'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONF     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES  = 2'd2;

    // Register reset values
    localparam logic [THRESH_W-1:0] MIN_CONF_RST     = 17'd16384;
    localparam logic [OFFSET_W-1:0] CLASS_OFFSET_RST = 16'd7680;
    localparam logic [NCLASS_W-1:0] NUM_CLASSES_RST  = 8'd80;

    // One finished row, handed from the row tracker to the decoder
    typedef struct packed {
        logic [VALUE_W-1:0] x;
        logic [VALUE_W-1:0] y;
        logic [VALUE_W-1:0] w;
        logic [VALUE_W-1:0] h;
        logic [VALUE_W-1:0] obj;
        logic [VALUE_W-1:0] best;
        logic [LABEL_W-1:0] label;
    } drdf_row_t;

endpackage
`default_nettype wire

>>> rtl/drdf_row_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drdf_row_tracker
// Tracks the row position, stores box fields and objectness, keeps a running
// class argmax and hands each finished row to the decoder.
// ----------------------------------------------------------------------------
module drdf_row_tracker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [drdf_pkg::VALUE_W-1:0]  s_value,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [drdf_pkg::NCLASS_W-1:0] num_classes,
    output logic                               row_valid,
    output drdf_pkg::drdf_row_t                row,
    input  wire logic                          row_ready
);
    import drdf_pkg::*;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [VALUE_W-1:0]  box_reg [4];
    logic [VALUE_W-1:0]  obj_reg;
    logic [VALUE_W-1:0]  best_reg, best_next;
    logic [LABEL_W-1:0]  label_reg, label_next;
    logic                row_valid_reg, row_valid_next;
    drdf_row_t           row_reg;

    logic [NCLASS_W-1:0] n_use;
    logic [POS_W-1:0]    last_pos;
    logic [LABEL_W-1:0]  cls;
    logic                row_end;
    logic                accept;
    logic                snap_free;

    assign snap_free = !row_valid_reg || row_ready;
    assign s_ready   = snap_free;
    assign accept    = s_valid && snap_free;

    always_comb begin
        n_use = num_classes;
        if (n_use == '0) begin
            n_use = NCLASS_W'(1);
        end
        if (n_use > CLASS_CAP_W) begin
            n_use = CLASS_CAP_W;
        end
    end

    assign last_pos = POS_BOX_END + POS_W'(n_use);
    assign row_end  = (pos_reg >= last_pos);
    assign cls      = pos_reg[LABEL_W-1:0] - POS_FIRST_CLASS[LABEL_W-1:0];

    always_comb begin
        best_next  = best_reg;
        label_next = label_reg;
        if (pos_reg > POS_OBJ) begin
            // first class score of the row always loads; ties keep the earlier one
            if ((pos_reg == POS_FIRST_CLASS) || ($signed(s_value) > $signed(best_reg))) begin
                best_next  = s_value;
                label_next = cls;
            end
        end
        pos_next = row_end ? '0 : pos_reg + POS_W'(1);
    end

    assign row_valid_next = snap_free ? (accept && row_end) : row_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            row_valid_reg <= 1'b0;
        end else begin
            row_valid_reg <= row_valid_next;
            if (accept) begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (pos_reg < POS_BOX_END) begin
                box_reg[pos_reg[1:0]] <= s_value;
            end
            if (pos_reg == POS_OBJ) begin
                obj_reg <= s_value;
            end
            best_reg  <= best_next;
            label_reg <= label_next;
            if (row_end) begin
                row_reg.x     <= box_reg[0];
                row_reg.y     <= box_reg[1];
                row_reg.w     <= box_reg[2];
                row_reg.h     <= box_reg[3];
                row_reg.obj   <= obj_reg;
                row_reg.best  <= best_next;
                row_reg.label <= label_next;
            end
        end
    end

    assign row_valid = row_valid_reg;
    assign row       = row_reg;

endmodule
`default_nettype wire

>>> rtl/drdf_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drdf_decode
// Forms the confidence of a finished row, filters it against the threshold
// and produces the offset box corners in the result register.
// ----------------------------------------------------------------------------
module drdf_decode (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          row_valid,
    input  wire drdf_pkg::drdf_row_t           row,
    output logic                               row_ready,
    input  wire logic [drdf_pkg::THRESH_W-1:0] min_conf,
    input  wire logic [drdf_pkg::OFFSET_W-1:0] class_offset,
    output logic signed [drdf_pkg::COORD_W-1:0] m_left,
    output logic signed [drdf_pkg::COORD_W-1:0] m_top,
    output logic signed [drdf_pkg::COORD_W-1:0] m_right,
    output logic signed [drdf_pkg::COORD_W-1:0] m_bottom,
    output logic [drdf_pkg::LABEL_W-1:0]       m_label,
    output logic signed [drdf_pkg::VALUE_W-1:0] m_score,
    output logic                               m_valid,
    input  wire logic                          m_ready
);
    import drdf_pkg::*;

    localparam int PROD_W = 2 * VALUE_W;
    localparam int CONF_W = PROD_W - FRAC_W;
    localparam logic signed [CONF_W-1:0] SAT_MAX = CONF_W'(64'sh7FFF_FFFF);
    localparam logic signed [CONF_W-1:0] SAT_MIN = -CONF_W'(64'sh8000_0000);

    // product stage
    logic                      pb_valid_reg, pb_valid_next;
    logic [PROD_W-1:0]         pb_prod_reg;
    logic [VALUE_W-1:0]        pb_x_reg, pb_y_reg, pb_hw_reg, pb_hh_reg;
    logic [OFF_PROD_W-1:0]     pb_off_reg;
    logic [LABEL_W-1:0]        pb_label_reg;

    // result register
    logic                      m_valid_reg, m_valid_next;
    logic [COORD_W-1:0]        left_reg, top_reg, right_reg, bottom_reg;
    logic [LABEL_W-1:0]        label_reg;
    logic [VALUE_W-1:0]        score_reg;

    logic                      out_free;
    logic                      pb_free;
    logic [PROD_W-1:0]         prod;
    logic signed [CONF_W-1:0]  conf;
    logic [VALUE_W-1:0]        score_sat;
    logic                      pass;
    logic [COORD_W-1:0]        off40, x40, y40, hw40, hh40;

    assign out_free  = !m_valid_reg || m_ready;
    assign pb_free   = !pb_valid_reg || out_free;
    assign row_ready = pb_free;

    assign prod = $signed({{VALUE_W{row.obj[VALUE_W-1]}}, row.obj})
                * $signed({{VALUE_W{row.best[VALUE_W-1]}}, row.best});

    assign pb_valid_next = pb_free ? row_valid : pb_valid_reg;

    // Q32.32 down to Q16.16 with floor, then clamp to 32-bit signed
    assign conf = $signed(pb_prod_reg[PROD_W-1:FRAC_W]);

    always_comb begin
        if (conf > SAT_MAX) begin
            score_sat = SAT_MAX[VALUE_W-1:0];
        end else if (conf < SAT_MIN) begin
            score_sat = SAT_MIN[VALUE_W-1:0];
        end else begin
            score_sat = conf[VALUE_W-1:0];
        end
    end

    assign pass = $signed(score_sat)
                > $signed({{(VALUE_W-THRESH_W){1'b0}}, min_conf});

    assign off40 = {{(COORD_W-OFF_PROD_W-FRAC_W){1'b0}}, pb_off_reg, {FRAC_W{1'b0}}};
    assign x40   = {{(COORD_W-VALUE_W){pb_x_reg[VALUE_W-1]}}, pb_x_reg};
    assign y40   = {{(COORD_W-VALUE_W){pb_y_reg[VALUE_W-1]}}, pb_y_reg};
    assign hw40  = {{(COORD_W-VALUE_W){pb_hw_reg[VALUE_W-1]}}, pb_hw_reg};
    assign hh40  = {{(COORD_W-VALUE_W){pb_hh_reg[VALUE_W-1]}}, pb_hh_reg};

    assign m_valid_next = out_free ? (pb_valid_reg && pass) : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pb_valid_reg <= pb_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pb_free && row_valid) begin
            pb_prod_reg  <= prod;
            pb_x_reg     <= row.x;
            pb_y_reg     <= row.y;
            // halve with arithmetic shift
            pb_hw_reg    <= {row.w[VALUE_W-1], row.w[VALUE_W-1:1]};
            pb_hh_reg    <= {row.h[VALUE_W-1], row.h[VALUE_W-1:1]};
            pb_off_reg   <= OFF_PROD_W'(row.label) * OFF_PROD_W'(class_offset);
            pb_label_reg <= row.label;
        end
        if (out_free && pb_valid_reg && pass) begin
            left_reg   <= x40 - hw40 + off40;
            top_reg    <= y40 - hh40 + off40;
            right_reg  <= x40 + hw40 + off40;
            bottom_reg <= y40 + hh40 + off40;
            label_reg  <= pb_label_reg;
            score_reg  <= score_sat;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_left   = $signed(left_reg);
    assign m_top    = $signed(top_reg);
    assign m_right  = $signed(right_reg);
    assign m_bottom = $signed(bottom_reg);
    assign m_label  = label_reg;
    assign m_score  = $signed(score_reg);

endmodule
`default_nettype wire

>>> rtl/detection_row_decode_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// detection_row_decode_filter
// Streams detector output rows and emits thresholded, class-offset boxes.
// ----------------------------------------------------------------------------
// The block takes one Q16.16 value per cycle while s_ready is high:
// centre x, centre y, width, height, objectness, then num_classes class
// scores per row, and rows follow each other with no gap. At the last
// value of a row the box passes through three registers: a row snapshot,
// the 32x32 confidence multiply stage and the result register. Rows whose
// confidence is at or below the minimum confidence produce no result. A
// stalled output holds only the later stages; input keeps flowing until a
// finished row has nowhere to go. Configuration registers (index 0 minimum
// confidence, 1 class_offset, 2 num_classes) are written with cfg_wr_en;
// other indexes are ignored.
// ----------------------------------------------------------------------------
module detection_row_decode_filter (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [drdf_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [drdf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic signed [drdf_pkg::VALUE_W-1:0] s_value,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    output logic signed [drdf_pkg::COORD_W-1:0]  m_left,
    output logic signed [drdf_pkg::COORD_W-1:0]  m_top,
    output logic signed [drdf_pkg::COORD_W-1:0]  m_right,
    output logic signed [drdf_pkg::COORD_W-1:0]  m_bottom,
    output logic [drdf_pkg::LABEL_W-1:0]         m_label,
    output logic signed [drdf_pkg::VALUE_W-1:0]  m_score,
    output logic                                 m_valid,
    input  wire logic                            m_ready
);
    import drdf_pkg::*;

    logic [THRESH_W-1:0] min_conf_reg;
    logic [OFFSET_W-1:0] class_offset_reg;
    logic [NCLASS_W-1:0] num_classes_reg;

    logic                row_valid;
    logic                row_ready;
    drdf_row_t           row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_conf_reg     <= MIN_CONF_RST;
            class_offset_reg <= CLASS_OFFSET_RST;
            num_classes_reg  <= NUM_CLASSES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_MIN_CONF: begin
                    min_conf_reg <= cfg_wr_data[THRESH_W-1:0];
                end
                CFG_CLASS_OFFSET: begin
                    class_offset_reg <= cfg_wr_data[OFFSET_W-1:0];
                end
                CFG_NUM_CLASSES: begin
                    num_classes_reg <= cfg_wr_data[NCLASS_W-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    drdf_row_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .num_classes (num_classes_reg),
        .row_valid   (row_valid),
        .row         (row),
        .row_ready   (row_ready)
    );

    drdf_decode u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .row_valid      (row_valid),
        .row            (row),
        .row_ready      (row_ready),
        .min_conf       (min_conf_reg),
        .class_offset   (class_offset_reg),
        .m_left         (m_left),
        .m_top          (m_top),
        .m_right        (m_right),
        .m_bottom       (m_bottom),
        .m_label        (m_label),
        .m_score        (m_score),
        .m_valid        (m_valid),
        .m_ready        (m_ready)
    );

endmodule
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the detection row decode filter.
// ----------------------------------------------------------------------------
// A short stimulus table covers register extremes, a confidence equal to the
// threshold, saturation, tied class scores and a class count change in the
// middle of a row. Random phases follow: each one programs new settings
// while the block is idle, then streams rows of mixed content, with some
// rows cut short and some bursts of raw noise. Every accepted value runs
// through a behavioral row decoder; each box leaving the block is compared
// field by field with the oldest predicted box. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import drdf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int     STALL_LIMIT   = 1000;
    localparam int     RANDOM_ITEMS  = 1000;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     TAIL_CYCLES   = 16;
    localparam longint CONF_MAX      = 64'sd2147483647;
    localparam longint CONF_MIN      = -64'sd2147483648;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
        logic [LABEL_W-1:0]        label;
        logic signed [VALUE_W-1:0] score;
    } box_t;

    typedef enum logic {STEP_CFG, STEP_VALUE} step_kind_t;

    typedef struct {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [VALUE_W-1:0]    value;
        bit                    typed;
        bit                    hit;
        box_t                  box;
    } stim_step_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_wr_index;
    logic [CFG_DATA_W-1:0]     cfg_wr_data;
    logic signed [VALUE_W-1:0] s_value;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [COORD_W-1:0] m_left;
    logic signed [COORD_W-1:0] m_top;
    logic signed [COORD_W-1:0] m_right;
    logic signed [COORD_W-1:0] m_bottom;
    logic [LABEL_W-1:0]        m_label;
    logic signed [VALUE_W-1:0] m_score;
    logic                      m_valid;
    logic                      m_ready;

    // Decoder copy of the registers and the row state
    logic [THRESH_W-1:0]       thr_q;
    logic [OFFSET_W-1:0]       off_px;
    logic [NCLASS_W-1:0]       class_cnt;
    logic [POS_W-1:0]          row_pos;
    logic signed [VALUE_W-1:0] row_box [4];
    logic signed [VALUE_W-1:0] row_obj;
    logic signed [VALUE_W-1:0] row_best;
    logic [LABEL_W-1:0]        row_label;

    box_t       pending_boxes[$];
    stim_step_t directed[$];

    int fail_count   = 0;
    int values_sent  = 0;
    int stall_cycles = 0;
    bit tx_calm;
    bit rx_calm;

    detection_row_decode_filter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_value      (s_value),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .m_left       (m_left),
        .m_top        (m_top),
        .m_right      (m_right),
        .m_bottom     (m_bottom),
        .m_label      (m_label),
        .m_score      (m_score),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int classes_active();
        int n;
        n = int'(class_cnt);
        if (n == 0) begin
            n = 1;
        end
        if (n > CLASS_CAP) begin
            n = CLASS_CAP;
        end
        return n;
    endfunction

    task automatic queue_box(input box_t b);
        pending_boxes.insert(pending_boxes.size(), b);
    endtask

    task automatic add_step(input stim_step_t s);
        directed.insert(directed.size(), s);
    endtask

    task automatic decode_value(input logic [VALUE_W-1:0] raw, output bit hit, output box_t b);
        logic signed [VALUE_W-1:0] v;
        int     last_pos;
        longint prod, conf, thr_l, off, hw, hh, x, y;
        v        = raw;
        hit      = 1'b0;
        b        = '0;
        last_pos = 4 + classes_active();
        if (row_pos < POS_BOX_END) begin
            row_box[row_pos[1:0]] = v;
        end else if (row_pos == POS_OBJ) begin
            row_obj = v;
        end else if (row_pos == POS_FIRST_CLASS || v > row_best) begin
            // strict compare: the first of equal scores keeps the label
            row_best  = v;
            row_label = LABEL_W'(row_pos - POS_FIRST_CLASS);
        end
        if (int'(row_pos) < last_pos) begin
            row_pos = row_pos + 8'd1;
        end else begin
            row_pos = '0;
            prod    = longint'(row_obj) * longint'(row_best);
            conf    = prod >>> 16;
            if (conf > CONF_MAX) begin
                conf = CONF_MAX;
            end
            if (conf < CONF_MIN) begin
                conf = CONF_MIN;
            end
            thr_l = {47'd0, thr_q};
            if (conf > thr_l) begin
                off      = longint'(row_label) * longint'(off_px) * 64'sd65536;
                x        = longint'(row_box[0]);
                y        = longint'(row_box[1]);
                hw       = longint'(row_box[2]) >>> 1;
                hh       = longint'(row_box[3]) >>> 1;
                b.left   = COORD_W'(x - hw + off);
                b.top    = COORD_W'(y - hh + off);
                b.right  = COORD_W'(x + hw + off);
                b.bottom = COORD_W'(y + hh + off);
                b.label  = row_label;
                b.score  = VALUE_W'(conf);
                hit      = 1'b1;
            end
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (index)
            CFG_MIN_CONF:     thr_q     = data[THRESH_W-1:0];
            CFG_CLASS_OFFSET: off_px    = data[OFFSET_W-1:0];
            CFG_NUM_CLASSES:  class_cnt = data[NCLASS_W-1:0];
            default: ;
        endcase
    endtask

    // Drop valid, drain every predicted box, then let a row with no box clear
    task automatic wait_quiet(input int settle);
        s_valid <= 1'b0;
        while (pending_boxes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (settle) @(posedge aclk);
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = tx_calm ? 0 : int'($urandom_range(0, 15));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        values_sent++;
    endtask

    task automatic feed(input logic [VALUE_W-1:0] v);
        bit   hit;
        box_t b;
        send_value(v);
        decode_value(v, hit, b);
        if (hit) begin
            queue_box(b);
        end
    endtask

    // Objectness and class scores: mostly values from 0.0 to 2.0, coarse steps for ties
    function automatic logic [VALUE_W-1:0] rand_level();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom();
            4:       return -$urandom_range(0, 65536);
            5, 6:    return $urandom_range(0, 16) << 12;
            default: return $urandom_range(0, 2 * 65536);
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 640 * 65536);
        endcase
    endfunction

    task automatic send_row();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] prev;
        repeat (4) feed(rand_coord());
        feed(rand_level());
        prev = rand_level();
        repeat (classes_active()) begin
            v = ($urandom_range(0, 4) == 0) ? prev : rand_level();
            feed(v);
            prev = v;
        end
    endtask

    task automatic program_settings();
        logic [CFG_DATA_W-1:0] thr, off, cnt;
        case ($urandom_range(0, 7))
            0:       thr = '0;
            1:       thr = 17'd65536;
            2:       thr = '1;
            3:       thr = 17'($urandom_range(0, 131071));
            default: thr = 17'($urandom_range(0, 65536));
        endcase
        case ($urandom_range(0, 5))
            0:       off = '0;
            1:       off = 17'h0_FFFF;
            default: off = 17'($urandom_range(0, 131071));
        endcase
        // keep most rows short; upper data bits carry junk now and then
        case ($urandom_range(0, 31))
            0:       cnt = '0;
            1:       cnt = 17'd128;
            2:       cnt = 17'($urandom_range(129, 255));
            3:       cnt = 17'(($urandom_range(0, 511) << 8) | $urandom_range(1, 8));
            default: cnt = 17'($urandom_range(1, 8));
        endcase
        cfg_write(CFG_MIN_CONF, thr);
        cfg_write(CFG_CLASS_OFFSET, off);
        cfg_write(CFG_NUM_CLASSES, cnt);
        if ($urandom_range(0, 3) == 0) begin
            cfg_write(CFG_UNUSED, 17'($urandom_range(0, 131071)));
        end
    endtask

    function automatic stim_step_t cfg_step(input logic [CFG_IDX_W-1:0] index,
                                            input logic [CFG_DATA_W-1:0] data);
        stim_step_t s;
        s.kind  = STEP_CFG;
        s.index = index;
        s.data  = data;
        s.value = '0;
        s.typed = 1'b0;
        s.hit   = 1'b0;
        s.box   = '0;
        return s;
    endfunction

    function automatic stim_step_t value_step(input logic [VALUE_W-1:0] v);
        stim_step_t s;
        s       = cfg_step(CFG_UNUSED, '0);
        s.kind  = STEP_VALUE;
        s.value = v;
        return s;
    endfunction

    function automatic stim_step_t row_end(input logic [VALUE_W-1:0] v, input bit hit,
                                           input logic signed [COORD_W-1:0] l,
                                           input logic signed [COORD_W-1:0] t,
                                           input logic signed [COORD_W-1:0] r,
                                           input logic signed [COORD_W-1:0] bt,
                                           input logic [LABEL_W-1:0] label,
                                           input logic signed [VALUE_W-1:0] score);
        stim_step_t s;
        s       = value_step(v);
        s.typed = 1'b1;
        s.hit   = hit;
        s.box   = '{left: l, top: t, right: r, bottom: bt, label: label, score: score};
        return s;
    endfunction

    initial begin : stimulus
        stim_step_t st;
        bit         hit;
        box_t       b;
        int         n;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data  = '0;
        s_value      = '0;
        s_valid      = 1'b0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        thr_q        = MIN_CONF_RST;
        off_px       = CLASS_OFFSET_RST;
        class_cnt    = NUM_CLASSES_RST;
        row_pos      = '0;
        foreach (row_box[k]) begin
            row_box[k] = '0;
        end
        row_obj   = '0;
        row_best  = '0;
        row_label = '0;

        // Zero classes behave as one; reset threshold and offset stay
        add_step(cfg_step(CFG_NUM_CLASSES, 17'd0));
        add_step(value_step(32'sd655360));
        add_step(value_step(32'sd1310720));
        add_step(value_step(32'sd262144));
        add_step(value_step(32'sd393216));
        add_step(value_step(32'sd65536));
        add_step(row_end(32'sd32768, 1'b1, 40'sd524288, 40'sd1114112,
                         40'sd786432, 40'sd1507328, 7'd0, 32'sd32768));
        // confidence equal to the threshold is dropped
        repeat (4) add_step(value_step(32'sd0));
        add_step(value_step(32'sd65536));
        add_step(row_end(32'sd16384, 1'b0, '0, '0, '0, '0, '0, '0));
        // extreme box fields, confidence saturated high
        add_step(value_step(32'h7FFF_FFFF));
        add_step(value_step(32'h8000_0000));
        add_step(value_step(32'h8000_0000));
        add_step(value_step(32'h7FFF_FFFF));
        add_step(value_step(32'h7FFF_FFFF));
        add_step(row_end(32'h7FFF_FFFF, 1'b1, 40'sd3221225471, -40'sd3221225471,
                         40'sd1073741823, -40'sd1073741825, 7'd0, 32'sh7FFF_FFFF));
        // tied scores, largest offset, count cut to one in mid-row
        add_step(cfg_step(CFG_MIN_CONF, 17'd0));
        add_step(cfg_step(CFG_CLASS_OFFSET, 17'h0_FFFF));
        add_step(cfg_step(CFG_NUM_CLASSES, 17'd3));
        add_step(value_step(32'sd0));
        add_step(value_step(32'sd0));
        add_step(value_step(32'hFFFF_FFFF));
        add_step(value_step(32'sd1));
        add_step(value_step(32'sd65536));
        add_step(value_step(32'sd5));
        add_step(value_step(32'sd7));
        add_step(cfg_step(CFG_NUM_CLASSES, 17'd0));
        add_step(cfg_step(CFG_UNUSED, 17'h1_FFFF));
        add_step(row_end(32'sd7, 1'b1, 40'sd4294901761, 40'sd4294901760,
                         40'sd4294901759, 40'sd4294901760, 7'd1, 32'sd7));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            st = directed[i];
            if (st.kind == STEP_CFG) begin
                wait_quiet(SETTLE_CYCLES);
                cfg_write(st.index, st.data);
            end else begin
                send_value(st.value);
                decode_value(st.value, hit, b);
                if (st.typed) begin
                    if (st.hit) begin
                        queue_box(st.box);
                    end
                end else if (hit) begin
                    queue_box(b);
                end
            end
        end

        values_sent = 0;
        while (values_sent < RANDOM_ITEMS) begin
            wait_quiet(SETTLE_CYCLES);
            program_settings();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            // close a row left open under the old count
            while (row_pos != '0) begin
                feed(rand_level());
            end
            n = classes_active();
            repeat ((n > 16) ? 1 : int'($urandom_range(2, 10))) send_row();
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4 + n)) feed(rand_level());
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 12)) feed($urandom());
            end
        end

        wait_quiet(TAIL_CYCLES);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : box_sink
        int hold;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            hold = rx_calm ? 0 : int'($urandom_range(0, 15));
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) begin
                @(posedge aclk);
            end
        end
    end

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : check_boxes
        box_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_boxes.size() == 0) begin
                $error("box with no prediction: label %0d score %0d", m_label, m_score);
                fail_count++;
            end else begin
                want = pending_boxes.pop_front();
                check_field("left", want.left, m_left);
                check_field("top", want.top, m_top);
                check_field("right", want.right, m_right);
                check_field("bottom", want.bottom, m_bottom);
                check_field("label", {57'd0, want.label}, {57'd0, m_label});
                check_field("score", want.score, m_score);
            end
        end
    end

    // End the run when neither channel moves a transaction for too long
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
`default_nettype wire
